// File: rtl/core/ach_pkg.sv
// ----------------------------------------------------------------------------
// ach_pkg
// Shared types and constants for the actuator command heartbeat block.
// ----------------------------------------------------------------------------
package ach_pkg;

  // Command codes
  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_STOP    = 3'd1;
  localparam logic [2:0] MODE_RUN_IN  = 3'd2;
  localparam logic [2:0] MODE_RUN_OUT = 3'd3;
  localparam logic [2:0] MODE_SPEED   = 3'd4;
  localparam logic [2:0] MODE_POS     = 3'd5;
  localparam logic [2:0] MODE_CLEAR   = 3'd6;
  localparam logic [2:0] MODE_NONE    = 3'd7;

  // Fixed payload templates, byte 0 in bits 63:56
  localparam logic [63:0] PAYLOAD_STOP  = 64'h03FB_FBFB_FBFB_FFFF;
  localparam logic [63:0] PAYLOAD_IN    = 64'h01FB_FBFB_FBFB_FFFF;
  localparam logic [63:0] PAYLOAD_OUT   = 64'h02FB_FBFB_FBFB_FFFF;
  localparam logic [63:0] PAYLOAD_CLEAR = 64'h00FB_FBFB_FBFB_FFFF;
  localparam logic [47:0] PAYLOAD_POS_LO = 48'hFBFB_FBFB_FFFF;

  // Clamp limits (Q8 units) and position saturation
  localparam logic [14:0] SPEED_MAX_Q8 = 15'd25600;
  localparam logic [20:0] POS_MAX_Q8   = 21'd1644928;
  localparam logic [15:0] POS_RAW_MAX  = 16'hFAFF;

  localparam logic [15:0] PERIOD_RESET = 16'd200;

  // Converted command operands, carried with the beat into stage 1
  typedef struct packed {
    logic [7:0]  speed_byte;
    logic [15:0] pos_raw;
  } conv_t;

endpackage

// File: rtl/core/ach_conv.sv
// ----------------------------------------------------------------------------
// ach_conv
// Converts speed and position operands to their payload encodings.
// ----------------------------------------------------------------------------
module ach_conv (
  input  logic signed [15:0] speed_q8,
  input  logic signed [23:0] position_q8,
  output ach_pkg::conv_t     conv
);

  logic [14:0] speed_clamp;
  logic [15:0] speed_round;
  logic [20:0] pos_clamp;
  logic [24:0] pos_scaled;
  logic [16:0] pos_shift;
  logic [15:0] pos_sat;

  // Clamp speed to 0..100 percent
  always_comb begin
    if (speed_q8[15]) begin
      speed_clamp = '0;
    end else if (speed_q8[14:0] > ach_pkg::SPEED_MAX_Q8) begin
      speed_clamp = ach_pkg::SPEED_MAX_Q8;
    end else begin
      speed_clamp = speed_q8[14:0];
    end
  end

  // (2*s + 128) >> 8 == (s + 64) >> 7
  assign speed_round = {1'b0, speed_clamp} + 16'd64;

  // Clamp position to 0..6425.5 mm
  always_comb begin
    if (position_q8[23]) begin
      pos_clamp = '0;
    end else if (position_q8[22:0] > {2'b00, ach_pkg::POS_MAX_Q8}) begin
      pos_clamp = ach_pkg::POS_MAX_Q8;
    end else begin
      pos_clamp = position_q8[20:0];
    end
  end

  // 10*p = 8p + 2p, plus half LSB before the shift
  assign pos_scaled = {1'b0, pos_clamp, 3'b000} + {3'b000, pos_clamp, 1'b0} + 25'd128;
  assign pos_shift  = pos_scaled[24:8];

  always_comb begin
    if (pos_shift > {1'b0, ach_pkg::POS_RAW_MAX}) begin
      pos_sat = ach_pkg::POS_RAW_MAX;
    end else begin
      pos_sat = pos_shift[15:0];
    end
  end

  assign conv = {speed_round[14:7], pos_sat};

endmodule

// File: rtl/core/actuator_command_heartbeat_core.sv
// ----------------------------------------------------------------------------
// actuator_command_heartbeat_core
// Holds the actuator command frame and repeats it on a tick-driven heartbeat.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake           Payload
//  -------  ------------------  ------------------------------------------
//  in       in_valid/in_ready   mode, can_id, speed_q8, position_q8
//  out      out_valid/out_ready frame_id, frame_payload
//  cfg      cfg_we              cfg_wdata (heartbeat period in ticks)
//
//  One beat per cycle while in_ready is high. Stage 1 registers the beat
//  with speed and position already converted; stage 2 updates the frame
//  and tick counter and loads the output register that raises out_valid.
//  in_ready drops only while a stage 1 beat waits behind a stalled frame.
//  Reset (rst, synchronous) loads the stop payload, clears the identifier,
//  its valid flag and the tick counter, and sets the period to 200.
//
module actuator_command_heartbeat_core (
  input  logic               clk,
  input  logic               rst,
  // command / tick beats
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         mode,
  input  logic [28:0]        can_id,
  input  logic signed [15:0] speed_q8,
  input  logic signed [23:0] position_q8,
  // emitted frames
  output logic               out_valid,
  input  logic               out_ready,
  output logic [28:0]        frame_id,
  output logic [63:0]        frame_payload,
  // heartbeat period register
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  // Stage 1: registered beat
  logic           s1_valid;
  logic [2:0]     s1_mode;
  logic [28:0]    s1_can_id;
  ach_pkg::conv_t s1_conv;
  ach_pkg::conv_t conv;

  // Block state
  logic [15:0] period;
  logic [63:0] command_payload;
  logic [63:0] command_payload_next;
  logic [28:0] target_id;
  logic        id_valid;
  logic [15:0] tick_count;
  logic [15:0] tick_count_next;

  // Stage 2 control
  logic        adv;        // stage 2 may hand a beat to the output register
  logic        s2_fire;    // stage 1 beat is consumed this cycle
  logic        is_cmd;     // beat carries a command that loads the id
  logic        emit;
  logic [15:0] period_eff;
  logic [16:0] tick_inc;
  logic        period_done;

  ach_conv u_conv (
    .speed_q8    (speed_q8),
    .position_q8 (position_q8),
    .conv        (conv)
  );

  assign adv      = !out_valid || out_ready;
  assign in_ready = !s1_valid || adv;
  assign s2_fire  = s1_valid && adv;

  // Period of zero behaves as one
  assign period_eff  = (period == '0) ? 16'd1 : period;
  assign tick_inc    = {1'b0, tick_count} + 17'd1;
  assign period_done = tick_inc >= {1'b0, period_eff};

  assign is_cmd = (s1_mode != ach_pkg::MODE_TICK) && (s1_mode != ach_pkg::MODE_NONE);
  assign emit   = s2_fire && (s1_mode == ach_pkg::MODE_TICK) && period_done && id_valid;

  // Next tick count
  always_comb begin
    tick_count_next = tick_count;
    if (s2_fire && (s1_mode == ach_pkg::MODE_TICK)) begin
      tick_count_next = period_done ? 16'd0 : tick_inc[15:0];
    end
  end

  // Next payload for each command
  always_comb begin
    command_payload_next = command_payload;
    unique case (s1_mode)
      ach_pkg::MODE_STOP:    command_payload_next = ach_pkg::PAYLOAD_STOP;
      ach_pkg::MODE_RUN_IN:  command_payload_next = ach_pkg::PAYLOAD_IN;
      ach_pkg::MODE_RUN_OUT: command_payload_next = ach_pkg::PAYLOAD_OUT;
      ach_pkg::MODE_SPEED:   command_payload_next[39:32] = s1_conv.speed_byte;
      ach_pkg::MODE_POS:
        command_payload_next = {s1_conv.pos_raw, ach_pkg::PAYLOAD_POS_LO};
      ach_pkg::MODE_CLEAR:   command_payload_next = ach_pkg::PAYLOAD_CLEAR;
      default:               command_payload_next = command_payload;  // tick, unused
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      period          <= ach_pkg::PERIOD_RESET;
      command_payload <= ach_pkg::PAYLOAD_STOP;
      target_id       <= '0;
      id_valid        <= 1'b0;
      tick_count      <= '0;
    end else begin
      if (cfg_we) begin
        period <= cfg_wdata;
      end

      if (in_ready) begin
        s1_valid <= in_valid;
      end

      tick_count <= tick_count_next;

      if (s2_fire && is_cmd) begin
        command_payload <= command_payload_next;
        target_id       <= s1_can_id;
        id_valid        <= 1'b1;
      end

      if (adv) begin
        out_valid <= emit;
      end
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode   <= mode;
      s1_can_id <= can_id;
      s1_conv   <= conv;
    end
    if (emit) begin
      frame_id      <= target_id;
      frame_payload <= command_payload;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A frame only ever leaves after an identifier was set
  a_frame_needs_id: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> id_valid)
    else $error("frame presented without a target identifier");

  // No command touches bytes 2, 4..7 of the stored payload
  a_fixed_bytes: assert property (@(posedge clk) disable iff (rst)
    (command_payload[15:0] == 16'hFFFF) && (command_payload[31:16] == 16'hFBFB) &&
    (command_payload[47:40] == 8'hFB))
    else $error("fixed payload bytes corrupted");

  // Input stalls only when a stage 1 beat is blocked by the output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without back-pressure");

  // A tick beat that completes a period restarts the counter
  a_tick_wrap: assert property (@(posedge clk) disable iff (rst)
    (s2_fire && (s1_mode == ach_pkg::MODE_TICK) && period_done) |=> (tick_count == '0))
    else $error("tick counter did not restart at period end");

endmodule

// File: tb/heartbeat_checker.sv
// ----------------------------------------------------------------------------
// heartbeat_checker
// Watches the beat, frame and period ports of the heartbeat core and keeps
// its own copy of the stored frame, identifier and tick counter. Each tick
// that completes a period with an identifier set queues a frame; each frame
// beat is compared against the oldest queued one.
// ----------------------------------------------------------------------------
module heartbeat_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         mode,
  input  logic [28:0]        can_id,
  input  logic signed [15:0] speed_q8,
  input  logic signed [23:0] position_q8,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [28:0]        frame_id,
  input  logic [63:0]        frame_payload,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output int unsigned        mismatches,
  output int unsigned        frames_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [28:0] id;
    logic [63:0] payload;
  } frame_t;

  frame_t      frames_due[$];
  logic [63:0] cmd_word;
  logic [28:0] target;
  logic        target_set;
  logic [15:0] tick_cnt;
  logic [15:0] period;

  // Q8.8 percent -> 2*percent, rounded half up
  function automatic logic [7:0] speed_to_byte(logic signed [15:0] sp);
    int v;
    v = sp;
    if (v < 0) v = 0;
    else if (v > int'(ach_pkg::SPEED_MAX_Q8)) v = int'(ach_pkg::SPEED_MAX_Q8);
    return 8'((2 * v + 128) >> 8);
  endfunction

  // Q16.8 mm -> tenths of a mm, rounded half up, saturated
  function automatic logic [15:0] position_to_tenths(logic signed [23:0] pos);
    int v;
    int raw;
    v = pos;
    if (v < 0) v = 0;
    else if (v > int'(ach_pkg::POS_MAX_Q8)) v = int'(ach_pkg::POS_MAX_Q8);
    raw = (10 * v + 128) >> 8;
    if (raw > int'(ach_pkg::POS_RAW_MAX)) raw = int'(ach_pkg::POS_RAW_MAX);
    return 16'(raw);
  endfunction

  always @(posedge clk) begin
    frame_t      got;
    frame_t      want;
    int unsigned nxt;
    int unsigned span;
    if (rst) begin
      cmd_word   = ach_pkg::PAYLOAD_STOP;
      target     = '0;
      target_set = 1'b0;
      tick_cnt   = '0;
      period     = ach_pkg::PERIOD_RESET;
      mismatches = 0;
      frames_due.delete();
    end else begin
      // frames first: a frame can never belong to the beat of this edge
      if (out_valid && out_ready) begin
        got = {frame_id, frame_payload};
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected frame id=%h payload=%h", $realtime,
                     got.id, got.payload);
        end else begin
          want = frames_due.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: frame mismatch id exp=%h got=%h payload exp=%h got=%h",
                       $realtime, want.id, got.id, want.payload, got.payload);
          end
        end
      end

      if (cfg_we) period = cfg_wdata;

      if (in_valid && in_ready) begin
        case (mode)
          ach_pkg::MODE_TICK: begin
            span = (period == 0) ? 1 : period;
            nxt  = tick_cnt + 1;
            if (nxt >= span) begin
              tick_cnt = '0;
              if (target_set) frames_due.push_back({target, cmd_word});
            end else begin
              tick_cnt = 16'(nxt);
            end
          end
          ach_pkg::MODE_NONE: ;
          default: begin
            target     = can_id;
            target_set = 1'b1;
            case (mode)
              ach_pkg::MODE_STOP:    cmd_word = ach_pkg::PAYLOAD_STOP;
              ach_pkg::MODE_RUN_IN:  cmd_word = ach_pkg::PAYLOAD_IN;
              ach_pkg::MODE_RUN_OUT: cmd_word = ach_pkg::PAYLOAD_OUT;
              ach_pkg::MODE_SPEED:   cmd_word[39:32] = speed_to_byte(speed_q8);
              ach_pkg::MODE_POS:
                cmd_word = {position_to_tenths(position_q8), ach_pkg::PAYLOAD_POS_LO};
              default:               cmd_word = ach_pkg::PAYLOAD_CLEAR;
            endcase
          end
        endcase
      end
    end
    frames_pending <= frames_due.size();
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives command and tick beats into the heartbeat core, stalls the frame
// side, steps the heartbeat period through its extremes between phases and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Frames become valid once their tick has passed stage 1 and the output
  // register; give the pipe some slack
  localparam int unsigned DRAIN_CYCLES = 4;
  // Cycles without any beat on either side before the run is abandoned
  localparam int unsigned CYCLE_LIMIT  = 2000;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [2:0]         mode          = ach_pkg::MODE_TICK;
  logic [28:0]        can_id        = '0;
  logic signed [15:0] speed_q8      = '0;
  logic signed [23:0] position_q8   = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [28:0]        frame_id;
  logic [63:0]        frame_payload;
  logic               cfg_we        = 1'b0;
  logic [15:0]        cfg_wdata     = '0;

  int unsigned mismatches;
  int unsigned frames_pending;
  int unsigned quiet_cycles = 0;

  // stall / gap controls, changed per phase
  bit tx_gaps    = 1'b0;
  bit rx_stalls  = 1'b0;
  bit calm_tail  = 1'b0;

  actuator_command_heartbeat_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .can_id        (can_id),
    .speed_q8      (speed_q8),
    .position_q8   (position_q8),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_id      (frame_id),
    .frame_payload (frame_payload),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  heartbeat_checker chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .can_id         (can_id),
    .speed_q8       (speed_q8),
    .position_q8    (position_q8),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_id       (frame_id),
    .frame_payload  (frame_payload),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .frames_pending (frames_pending)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: any accepted beat on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Frame side: ready mostly high, dropped in bursts when the phase allows
  // it. A burst ends with ready raised on its last edge, so each edge sees
  // at most one assignment.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_stalls && !calm_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // One beat on the command channel. An optional gap goes first; valid is
  // left high on acceptance so back-to-back beats need no second write.
  task automatic put_beat(input logic [2:0] m, input logic [28:0] id,
                          input logic signed [15:0] sp,
                          input logic signed [23:0] pos);
    if (tx_gaps && !calm_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    can_id      <= id;
    speed_q8    <= sp;
    position_q8 <= pos;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every queued frame is out, then let the
  // pipe run empty; a tick with no frame may still be in flight.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Period writes only happen with the block drained
  task automatic set_period(input logic [15:0] ticks);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Roughly half ticks, a few unused codes, the rest commands. Speed is
  // raw 16-bit noise or inside the clamp window; position is raw 24-bit
  // noise, near the clamp limit or inside it, so the rounding paths get exercised.
  task automatic put_random_beat();
    logic [2:0]         m;
    logic [28:0]        id;
    logic signed [15:0] sp;
    logic signed [23:0] pos;
    int unsigned        r;
    r = $urandom_range(0, 99);
    if (r < 48) m = ach_pkg::MODE_TICK;
    else if (r < 52) m = ach_pkg::MODE_NONE;
    else m = 3'($urandom_range(ach_pkg::MODE_STOP, ach_pkg::MODE_CLEAR));
    case ($urandom_range(0, 9))
      0:       id = '0;
      1:       id = '1;
      default: id = 29'($urandom);
    endcase
    if ($urandom_range(0, 1) == 0) sp = 16'($urandom);
    else sp = 16'($urandom_range(0, ach_pkg::SPEED_MAX_Q8));
    case ($urandom_range(0, 3))
      0:       pos = 24'($urandom);
      1:       pos = 24'($urandom_range(ach_pkg::POS_MAX_Q8 - 3000,
                                        ach_pkg::POS_MAX_Q8 + 3000));
      default: pos = 24'($urandom_range(0, ach_pkg::POS_MAX_Q8));
    endcase
    put_beat(m, id, sp, pos);
  endtask

  // A phase: one period setting, fresh gap/stall choices, random beats.
  // Now and then the sender waits for all frames to drain mid-phase.
  task automatic run_phase(input logic [15:0] ticks, input int unsigned beats);
    set_period(ticks);
    tx_gaps   = ($urandom_range(0, 3) != 0);
    rx_stalls <= ($urandom_range(0, 3) != 0);
    repeat (beats) begin
      if (!calm_tail && $urandom_range(0, 59) == 0) settle();
      put_random_beat();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---------------------------------------------------------
    // Tick at the reset period of 200, no identifier yet
    put_beat(ach_pkg::MODE_TICK, 29'($urandom), 16'($urandom), 24'($urandom));
    set_period(16'd1);
    // Period completes without an identifier: counter restarts, no frame
    put_beat(ach_pkg::MODE_TICK, 29'($urandom), 16'($urandom), 24'($urandom));
    // Unused code: must not set the identifier
    put_beat(ach_pkg::MODE_NONE, 29'($urandom), 16'($urandom), 24'($urandom));
    put_beat(ach_pkg::MODE_STOP, 29'h0, 16'sd0, 24'sd0);
    put_beat(ach_pkg::MODE_TICK, '0, '0, '0);
    put_beat(ach_pkg::MODE_RUN_IN, 29'h1FFF_FFFF, -16'sd1, -24'sd1);
    put_beat(ach_pkg::MODE_TICK, '1, '1, '1);
    put_beat(ach_pkg::MODE_RUN_OUT, 29'($urandom), 16'($urandom), 24'($urandom));
    put_beat(ach_pkg::MODE_CLEAR, 29'($urandom), 16'($urandom), 24'($urandom));
    put_beat(ach_pkg::MODE_TICK, 29'($urandom), '0, '0);
    // Speed clamps low, clamps high, rounds half up, rounds down
    put_beat(ach_pkg::MODE_SPEED, 29'($urandom), 16'sh8000, '0);
    put_beat(ach_pkg::MODE_TICK, '0, '0, '0);
    put_beat(ach_pkg::MODE_SPEED, 29'($urandom), 16'sd32767, '0);
    put_beat(ach_pkg::MODE_TICK, '0, '0, '0);
    put_beat(ach_pkg::MODE_SPEED, 29'($urandom), 16'sd64, '0);
    put_beat(ach_pkg::MODE_TICK, '0, '0, '0);
    put_beat(ach_pkg::MODE_SPEED, 29'($urandom), 16'sd63, '0);
    put_beat(ach_pkg::MODE_TICK, '0, '0, '0);
    // Position clamps low, clamps and saturates high, rounds half up
    put_beat(ach_pkg::MODE_POS, 29'($urandom), '0, 24'sh800000);
    put_beat(ach_pkg::MODE_TICK, '0, '0, '0);
    put_beat(ach_pkg::MODE_POS, 29'($urandom), '0, 24'sd8388607);
    put_beat(ach_pkg::MODE_TICK, '0, '0, '0);
    put_beat(ach_pkg::MODE_POS, 29'($urandom), '0, 24'sd13);
    put_beat(ach_pkg::MODE_TICK, '0, '0, '0);

    // Period lowered below the running count: next tick completes it
    set_period(16'd200);
    put_beat(ach_pkg::MODE_RUN_IN, 29'($urandom), '0, '0);
    repeat (40) put_beat(ach_pkg::MODE_TICK, '0, '0, '0);
    set_period(16'd5);
    put_beat(ach_pkg::MODE_TICK, '0, '0, '0);

    // --- random -----------------------------------------------------------
    run_phase(16'd0, 70);                      // zero acts as one
    run_phase(16'hFFFF, 40);                   // longest period
    run_phase(16'($urandom_range(9, 300)), 40);
    repeat (6) run_phase(16'($urandom_range(1, 8)), 85);
    calm_tail = 1'b1;                          // no gaps, no stalls from here
    run_phase(16'($urandom_range(1, 4)), 80);

    settle();
    if (mismatches == 0 && frames_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/ach_pkg.sv
rtl/core/ach_conv.sv
rtl/core/actuator_command_heartbeat_core.sv
tb/heartbeat_checker.sv
tb/testbench.sv
